// ===== hdl/obb_pkg.sv =====
package obb_pkg;

	// Field widths of one item.
	localparam int CW  = 24;          // center coordinate, signed Q15.8
	localparam int AXW = 16;          // axis component, signed Q1.F
	localparam int HW  = 23;          // half extent, unsigned Q15.8

	// Internal widths.
	localparam int DW  = CW + 1;      // center difference
	localparam int PW  = 2 * AXW;     // axis-by-axis product, signed
	localparam int SQW = 2 * AXW;     // magnitude of a two-term axis dot product
	localparam int DPW = DW + AXW;    // center-difference-by-axis product, signed
	localparam int DMW = DPW;         // magnitude of a two-term distance dot product
	localparam int RPW = SQW + HW;    // one radius term
	localparam int RW  = RPW + 2;     // sum of three radius terms

	localparam int NAX = 4;           // candidate separating axes

	typedef logic signed [PW-1:0]  aprod_t;
	typedef logic signed [DPW-1:0] dprod_t;

	// Everything stage two hands to the projection stages.
	typedef struct packed {
		logic [SQW-1:0] sa;       // |rA.rA|
		logic [SQW-1:0] sb;       // |rB.rB|
		logic [SQW-1:0] c;        // |rA.rB|
		logic [SQW-1:0] s;        // |rA.uB|
		logic [HW-1:0]  ahw;
		logic [HW-1:0]  ahh;
		logic [HW-1:0]  bhw;
		logic [HW-1:0]  bhh;
		dprod_t         dx_arx;
		dprod_t         dy_ary;
		dprod_t         dy_arx;
		dprod_t         dx_ary;
		dprod_t         dx_brx;
		dprod_t         dy_bry;
		dprod_t         dy_brx;
		dprod_t         dx_bry;
	} dots_t;

	// Per-axis center distance and summed radii.
	typedef struct packed {
		logic [NAX-1:0][DMW-1:0] cdist;
		logic [NAX-1:0][RW-1:0]  rad;
	} proj_t;

	function automatic logic [SQW-1:0] mag_axis(input logic signed [PW:0] v);
		logic [PW:0] n;
		n = v[PW] ? (~v + 1'b1) : v;
		return n[SQW-1:0];
	endfunction

	function automatic logic [DMW-1:0] mag_dist(input logic signed [DPW:0] v);
		logic [DPW:0] n;
		n = v[DPW] ? (~v + 1'b1) : v;
		return n[DMW-1:0];
	endfunction

endpackage

// ===== hdl/obb_overlap_test.sv =====
// Oriented box overlap test, 2D separating axis theorem, fixed point.
//
// Input channel: the caller drives both boxes on the a_* and b_* ports and
// raises start. An item is taken at every rising edge where start is high and
// busy is low. busy never rises: the pipeline has no stall point, so one item
// can be taken in every cycle, back to back.
//
// Result channel: done is high for exactly one cycle, with overlap valid in
// that same cycle. The receiver cannot hold a result off and need not: one
// result leaves for every item, in the order the items came in.
//
// Throughput is one item per cycle. The five register stages, in order, are
// axis products, axis magnitudes with distance products, radius products,
// radius sums, and the final compare into the result register; an item's
// result shows once it has passed all five.
//
// Reset clears the valid bits of every stage and the done strobe, so no
// result appears for items that were in flight when reset arrived.
module obb_overlap_test #(
	parameter int AXIS_FRAC_BITS = 14
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [obb_pkg::CW-1:0]  a_center_x,
	input  logic signed [obb_pkg::CW-1:0]  a_center_y,
	input  logic signed [obb_pkg::AXW-1:0] a_axis_x,
	input  logic signed [obb_pkg::AXW-1:0] a_axis_y,
	input  logic        [obb_pkg::HW-1:0]  a_half_width,
	input  logic        [obb_pkg::HW-1:0]  a_half_height,
	input  logic signed [obb_pkg::CW-1:0]  b_center_x,
	input  logic signed [obb_pkg::CW-1:0]  b_center_y,
	input  logic signed [obb_pkg::AXW-1:0] b_axis_x,
	input  logic signed [obb_pkg::AXW-1:0] b_axis_y,
	input  logic        [obb_pkg::HW-1:0]  b_half_width,
	input  logic        [obb_pkg::HW-1:0]  b_half_height,
	output logic                           done,
	output logic                           overlap
);
	import obb_pkg::*;

	// The center projection is in Q(F+8) while radii are in Q(2F+8), so the
	// distance is scaled up by F bits before the compare. The compare width
	// covers whichever side is wider.
	localparam int CMPW = (DMW + AXIS_FRAC_BITS > RW) ? DMW + AXIS_FRAC_BITS : RW;

	logic   accept;
	logic   v_s2, v_s4;
	dots_t  dots_s2;
	proj_t  proj_s4;
	logic [NAX-1:0] sep;
	logic   done_q, overlap_q;

	// Nothing ever stalls the pipeline, so every start is taken.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	obb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (accept),
		.a_center_x    (a_center_x),
		.a_center_y    (a_center_y),
		.a_axis_x      (a_axis_x),
		.a_axis_y      (a_axis_y),
		.a_half_width  (a_half_width),
		.a_half_height (a_half_height),
		.b_center_x    (b_center_x),
		.b_center_y    (b_center_y),
		.b_axis_x      (b_axis_x),
		.b_axis_y      (b_axis_y),
		.b_half_width  (b_half_width),
		.b_half_height (b_half_height),
		.v_s2          (v_s2),
		.dots_s2       (dots_s2)
	);

	obb_proj u_proj (
		.clk     (clk),
		.arst_n  (arst_n),
		.v_s2    (v_s2),
		.dots_s2 (dots_s2),
		.v_s4    (v_s4),
		.proj_s4 (proj_s4)
	);

	// An axis separates the boxes when the scaled center distance is strictly
	// greater than the summed radii. Touching counts as overlap.
	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			sep[i] = (CMPW'(proj_s4.cdist[i]) << AXIS_FRAC_BITS) > CMPW'(proj_s4.rad[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		overlap_q <= ~|sep;
	end

	assign done    = done_q;
	assign overlap = overlap_q;

endmodule

// ===== hdl/obb_front.sv =====
module obb_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [obb_pkg::CW-1:0]  a_center_x,
	input  logic signed [obb_pkg::CW-1:0]  a_center_y,
	input  logic signed [obb_pkg::AXW-1:0] a_axis_x,
	input  logic signed [obb_pkg::AXW-1:0] a_axis_y,
	input  logic        [obb_pkg::HW-1:0]  a_half_width,
	input  logic        [obb_pkg::HW-1:0]  a_half_height,
	input  logic signed [obb_pkg::CW-1:0]  b_center_x,
	input  logic signed [obb_pkg::CW-1:0]  b_center_y,
	input  logic signed [obb_pkg::AXW-1:0] b_axis_x,
	input  logic signed [obb_pkg::AXW-1:0] b_axis_y,
	input  logic        [obb_pkg::HW-1:0]  b_half_width,
	input  logic        [obb_pkg::HW-1:0]  b_half_height,
	output logic                           v_s2,
	output obb_pkg::dots_t                 dots_s2
);
	import obb_pkg::*;

	// Stage one: center differences and the axis-by-axis products.
	logic                  v_s1;
	logic signed [DW-1:0]  dx_s1, dy_s1;
	logic signed [AXW-1:0] arx_s1, ary_s1, brx_s1, bry_s1;
	logic [HW-1:0]         ahw_s1, ahh_s1, bhw_s1, bhh_s1;
	aprod_t                aa_xx_s1, aa_yy_s1, bb_xx_s1, bb_yy_s1;
	aprod_t                ab_xx_s1, ab_yy_s1, ab_xy_s1, ab_yx_s1;

	logic signed [PW:0] sa_sum, sb_sum, c_sum, s_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1    <= DW'(b_center_x) - DW'(a_center_x);
		dy_s1    <= DW'(b_center_y) - DW'(a_center_y);
		arx_s1   <= a_axis_x;
		ary_s1   <= a_axis_y;
		brx_s1   <= b_axis_x;
		bry_s1   <= b_axis_y;
		ahw_s1   <= a_half_width;
		ahh_s1   <= a_half_height;
		bhw_s1   <= b_half_width;
		bhh_s1   <= b_half_height;
		aa_xx_s1 <= PW'(a_axis_x) * PW'(a_axis_x);
		aa_yy_s1 <= PW'(a_axis_y) * PW'(a_axis_y);
		bb_xx_s1 <= PW'(b_axis_x) * PW'(b_axis_x);
		bb_yy_s1 <= PW'(b_axis_y) * PW'(b_axis_y);
		ab_xx_s1 <= PW'(a_axis_x) * PW'(b_axis_x);
		ab_yy_s1 <= PW'(a_axis_y) * PW'(b_axis_y);
		ab_xy_s1 <= PW'(a_axis_x) * PW'(b_axis_y);
		ab_yx_s1 <= PW'(a_axis_y) * PW'(b_axis_x);
	end

	// The up axis is (-y, x). Every cross term between the four axes reduces
	// to one of four magnitudes: |rA|^2, |rB|^2, |rA.rB| and |rA.uB|. The
	// dot product of a box's right axis with its own up axis is exactly zero.
	always_comb begin
		sa_sum = (PW+1)'(aa_xx_s1) + (PW+1)'(aa_yy_s1);
		sb_sum = (PW+1)'(bb_xx_s1) + (PW+1)'(bb_yy_s1);
		c_sum  = (PW+1)'(ab_xx_s1) + (PW+1)'(ab_yy_s1);
		s_sum  = (PW+1)'(ab_yx_s1) - (PW+1)'(ab_xy_s1);
	end

	// Stage two: axis magnitudes and the center-difference products.
	always_ff @(posedge clk) begin
		dots_s2.sa     <= mag_axis(sa_sum);
		dots_s2.sb     <= mag_axis(sb_sum);
		dots_s2.c      <= mag_axis(c_sum);
		dots_s2.s      <= mag_axis(s_sum);
		dots_s2.ahw    <= ahw_s1;
		dots_s2.ahh    <= ahh_s1;
		dots_s2.bhw    <= bhw_s1;
		dots_s2.bhh    <= bhh_s1;
		dots_s2.dx_arx <= DPW'(dx_s1) * DPW'(arx_s1);
		dots_s2.dy_ary <= DPW'(dy_s1) * DPW'(ary_s1);
		dots_s2.dy_arx <= DPW'(dy_s1) * DPW'(arx_s1);
		dots_s2.dx_ary <= DPW'(dx_s1) * DPW'(ary_s1);
		dots_s2.dx_brx <= DPW'(dx_s1) * DPW'(brx_s1);
		dots_s2.dy_bry <= DPW'(dy_s1) * DPW'(bry_s1);
		dots_s2.dy_brx <= DPW'(dy_s1) * DPW'(brx_s1);
		dots_s2.dx_bry <= DPW'(dx_s1) * DPW'(bry_s1);
	end

endmodule

// ===== hdl/obb_proj.sv =====
module obb_proj (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           v_s2,
	input  obb_pkg::dots_t dots_s2,
	output logic           v_s4,
	output obb_pkg::proj_t proj_s4
);
	import obb_pkg::*;

	logic                    v_s3;
	logic [NAX-1:0][DMW-1:0] cdist_s3;
	logic [RPW-1:0]          sa_ahw_s3, sa_ahh_s3, sb_bhw_s3, sb_bhh_s3;
	logic [RPW-1:0]          c_ahw_s3, c_ahh_s3, c_bhw_s3, c_bhh_s3;
	logic [RPW-1:0]          s_ahw_s3, s_ahh_s3, s_bhw_s3, s_bhh_s3;

	logic signed [DPW:0] d0, d1, d2, d3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Projected center distance on rA, uA, rB and uB in that order.
	always_comb begin
		d0 = (DPW+1)'(dots_s2.dx_arx) + (DPW+1)'(dots_s2.dy_ary);
		d1 = (DPW+1)'(dots_s2.dy_arx) - (DPW+1)'(dots_s2.dx_ary);
		d2 = (DPW+1)'(dots_s2.dx_brx) + (DPW+1)'(dots_s2.dy_bry);
		d3 = (DPW+1)'(dots_s2.dy_brx) - (DPW+1)'(dots_s2.dx_bry);
	end

	// Stage three: distance magnitudes and the twelve radius terms.
	always_ff @(posedge clk) begin
		cdist_s3[0] <= mag_dist(d0);
		cdist_s3[1] <= mag_dist(d1);
		cdist_s3[2] <= mag_dist(d2);
		cdist_s3[3] <= mag_dist(d3);
		sa_ahw_s3   <= RPW'(dots_s2.sa) * RPW'(dots_s2.ahw);
		sa_ahh_s3   <= RPW'(dots_s2.sa) * RPW'(dots_s2.ahh);
		sb_bhw_s3   <= RPW'(dots_s2.sb) * RPW'(dots_s2.bhw);
		sb_bhh_s3   <= RPW'(dots_s2.sb) * RPW'(dots_s2.bhh);
		c_ahw_s3    <= RPW'(dots_s2.c)  * RPW'(dots_s2.ahw);
		c_ahh_s3    <= RPW'(dots_s2.c)  * RPW'(dots_s2.ahh);
		c_bhw_s3    <= RPW'(dots_s2.c)  * RPW'(dots_s2.bhw);
		c_bhh_s3    <= RPW'(dots_s2.c)  * RPW'(dots_s2.bhh);
		s_ahw_s3    <= RPW'(dots_s2.s)  * RPW'(dots_s2.ahw);
		s_ahh_s3    <= RPW'(dots_s2.s)  * RPW'(dots_s2.ahh);
		s_bhw_s3    <= RPW'(dots_s2.s)  * RPW'(dots_s2.bhw);
		s_bhh_s3    <= RPW'(dots_s2.s)  * RPW'(dots_s2.bhh);
	end

	// Stage four: sum of both boxes' radii on each axis. On a box's own
	// axes one of its two terms is zero, so each sum has three terms.
	always_ff @(posedge clk) begin
		proj_s4.cdist  <= cdist_s3;
		proj_s4.rad[0] <= RW'(sa_ahw_s3) + RW'(c_bhw_s3) + RW'(s_bhh_s3);
		proj_s4.rad[1] <= RW'(sa_ahh_s3) + RW'(s_bhw_s3) + RW'(c_bhh_s3);
		proj_s4.rad[2] <= RW'(c_ahw_s3)  + RW'(s_ahh_s3) + RW'(sb_bhw_s3);
		proj_s4.rad[3] <= RW'(s_ahw_s3)  + RW'(c_ahh_s3) + RW'(sb_bhh_s3);
	end

endmodule

// ===== hdl/obb_chk.sv =====
module obb_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           done,
	input logic                           overlap,
	input logic signed [obb_pkg::CW-1:0]  a_center_x,
	input logic signed [obb_pkg::CW-1:0]  a_center_y,
	input logic signed [obb_pkg::CW-1:0]  b_center_x,
	input logic signed [obb_pkg::CW-1:0]  b_center_y,
	input logic signed [obb_pkg::AXW-1:0] a_axis_x,
	input logic signed [obb_pkg::AXW-1:0] a_axis_y,
	input logic signed [obb_pkg::AXW-1:0] b_axis_x,
	input logic signed [obb_pkg::AXW-1:0] b_axis_y
);

	// Every item taken yields a result as it leaves the pipeline.
	a_accept_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("item taken without a result five cycles later");

	// No result without a matching item taken.
	a_done_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without a matching item");

	// Boxes with the same center always overlap.
	a_same_center: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && a_center_x == b_center_x && a_center_y == b_center_y)
		|-> ##5 (done && overlap))
		else $error("boxes with a common center reported as separated");

	// With all axes zero no axis can separate the boxes.
	a_zero_axes: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && a_axis_x == 0 && a_axis_y == 0 &&
		 b_axis_x == 0 && b_axis_y == 0) |-> ##5 (done && overlap))
		else $error("zero axes reported as separated");

endmodule

bind obb_overlap_test obb_chk u_obb_chk (.*);
